// File: hdl/tga_rle_pkg.sv
// Package for the TGA run-length pixel encoder.
// Holds sizes, chunk and job codes, sequencer states and the pixel mask function.
// No dependencies.
package tga_rle_pkg;

  localparam int MaxPacketPixels = 128;
  localparam int PixelsPerResult = 4;
  localparam int AddrW           = $clog2(MaxPacketPixels);
  localparam int CntW            = $clog2(MaxPacketPixels) + 1;
  localparam int SlotW           = 2;
  localparam int PixW            = 32;
  localparam int PaddrW          = 3;

  localparam logic [2:0]      ChanCountReset = 3'd3;
  localparam logic [CntW-1:0] RunHeaderBias  = CntW'(127);

  typedef enum logic [1:0] {
    M_EMPTY  = 2'd0,
    M_SINGLE = 2'd1,
    M_RAW    = 2'd2,
    M_RUN    = 2'd3
  } chunk_mode_e;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_RAW  = 2'd1,
    JOB_RUN  = 2'd2
  } job_kind_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_RD   = 4'b0100,
    S_PUSH = 4'b1000
  } seq_state_e;

  typedef struct packed {
    job_kind_e       kind;
    logic [CntW-1:0] cnt;
    logic [PixW-1:0] val;
  } job_t;

  function automatic logic [PixW-1:0] pixel_mask(input logic [2:0] chan);
    logic [PixW-1:0] m;
    case (chan)
      3'd0, 3'd1: m = 32'h0000_00FF;
      3'd2:       m = 32'h0000_FFFF;
      3'd3:       m = 32'h00FF_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/tga_rle_pixel_encoder_unit.sv
// TGA run-length pixel encoder: chunk store memory, chunk tracking and sequencer; uses tga_rle_pkg.
// A pixel that closes no packet leaves input ready high; the next pixel is accepted in the next cycle.
// A run packet goes from S_RUN into the output register once the output is free. Raw packets are
// read from the chunk store in S_RD, one read a cycle, and pushed in items of up to 4 pixels.
// Input ready is low while packets drain. Reset clears control state and sets channel_count
// to 3; the chunk store is not cleared and needs no clearing pass.
module tga_rle_pixel_encoder_unit import tga_rle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixW-1:0]   pixel_value_i,
  input  logic              final_pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              header_present_o,
  output logic [7:0]        header_byte_o,
  output logic [2:0]        pixel_count_o,
  output logic [PixW-1:0]   pixel_slot0_o,
  output logic [PixW-1:0]   pixel_slot1_o,
  output logic [PixW-1:0]   pixel_slot2_o,
  output logic [PixW-1:0]   pixel_slot3_o,
  output logic              packet_end_o,
  output logic              image_end_o
);

  logic [2:0]       channel_count_q;
  chunk_mode_e      mode_q, mode_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [PixW-1:0]  pend_q;
  seq_state_e       state_q, state_d;

  logic [PixW-1:0]  store_mem [MaxPacketPixels];
  logic [PixW-1:0]  rdata_q;
  logic             rd_en;
  logic             rd_vld_q;
  logic [SlotW-1:0] rd_slot_q;
  logic [PixW-1:0]  asm_q [PixelsPerResult];
  logic [PixW-1:0]  merged [PixelsPerResult];

  job_t             cur_q, nxt_q, j1, j2, new_job;
  logic             nxt_vld_q, fin_q, first_q;
  logic [CntW-1:0]  pix_idx_q;
  logic [SlotW-1:0] slot_idx_q;
  logic [2:0]       item_k_q;

  logic             acc, eq, wr_en, load_job, finish, push_run, push_raw, out_free, last_pkt;
  logic             item_done;
  logic [AddrW-1:0] wr_addr;
  logic [PixW-1:0]  mask, pix;

  logic             out_valid_q;
  logic             hp_q, pe_q, ie_q;
  logic [7:0]       hb_q;
  logic [2:0]       pc_q;
  logic [PixW-1:0]  slot_q [PixelsPerResult];

  // configuration
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, channel_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= ChanCountReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      channel_count_q <= pwdata[2:0];
    end
  end

  // chunk tracking on each accepted pixel
  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign mask       = pixel_mask(channel_count_q);
  assign pix        = pixel_value_i & mask;
  assign eq         = ((pend_q ^ pix) & mask) == '0;

  always_comb begin
    j1      = '{kind: JOB_NONE, cnt: '0, val: '0};
    j2      = '{kind: JOB_NONE, cnt: '0, val: '0};
    wr_en   = 1'b0;
    wr_addr = '0;
    mode_d  = mode_q;
    len_d   = len_q;
    case (mode_q)
      M_EMPTY: begin
        wr_en  = 1'b1;
        mode_d = M_SINGLE;
        len_d  = CntW'(1);
      end
      M_SINGLE: begin
        len_d = CntW'(2);
        if (eq) begin
          mode_d = M_RUN;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AddrW'(1);
          mode_d  = M_RAW;
        end
      end
      M_RAW: begin
        if (eq) begin
          j1     = '{kind: JOB_RAW, cnt: len_q - CntW'(1), val: '0};
          mode_d = M_RUN;
          len_d  = CntW'(2);
        end else begin
          wr_en   = !len_q[CntW-1];
          wr_addr = len_q[AddrW-1:0];
          len_d   = len_q + CntW'(1);
        end
      end
      M_RUN: begin
        if (eq) begin
          len_d = len_q + CntW'(1);
        end else begin
          j1     = '{kind: JOB_RUN, cnt: len_q, val: pend_q};
          wr_en  = 1'b1;
          mode_d = M_SINGLE;
          len_d  = CntW'(1);
        end
      end
      default: begin
        mode_d = M_EMPTY;
        len_d  = '0;
      end
    endcase
    if (len_d[CntW-1] || final_pixel_i) begin
      case (mode_d)
        M_RUN:    j2 = '{kind: JOB_RUN, cnt: len_d, val: pix};
        M_RAW:    j2 = '{kind: JOB_RAW, cnt: len_d, val: '0};
        M_SINGLE: j2 = '{kind: JOB_RAW, cnt: CntW'(1), val: '0};
        default:  j2 = '{kind: JOB_NONE, cnt: '0, val: '0};
      endcase
      mode_d = M_EMPTY;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_EMPTY;
      len_q  <= '0;
      pend_q <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      pend_q <= pix;
    end
  end

  // chunk store
  always_ff @(posedge clk_i) begin
    if (acc && wr_en) begin
      store_mem[wr_addr] <= pix;
    end
    if (rd_en) begin
      rdata_q <= store_mem[pix_idx_q[AddrW-1:0]];
    end
  end

  // packet sequencer
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_pkt  = (pix_idx_q == cur_q.cnt);
  assign item_done = (slot_idx_q == SlotW'(PixelsPerResult - 1)) ||
                     (pix_idx_q == cur_q.cnt - CntW'(1));

  always_comb begin
    state_d  = state_q;
    load_job = 1'b0;
    new_job  = j1;
    finish   = 1'b0;
    push_run = 1'b0;
    push_raw = 1'b0;
    rd_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (j1.kind != JOB_NONE) begin
            load_job = 1'b1;
          end else if (j2.kind != JOB_NONE) begin
            load_job = 1'b1;
            new_job  = j2;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          push_run = 1'b1;
          finish   = 1'b1;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        if (item_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          push_raw = 1'b1;
          if (last_pkt) begin
            finish = 1'b1;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (finish) begin
      if (nxt_vld_q) begin
        load_job = 1'b1;
        new_job  = nxt_q;
      end else begin
        state_d = S_IDLE;
      end
    end
    if (load_job) begin
      state_d = (new_job.kind == JOB_RUN) ? S_RUN : S_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nxt_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (acc) begin
        nxt_vld_q <= (j1.kind != JOB_NONE) && (j2.kind != JOB_NONE);
      end else if (finish) begin
        nxt_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      nxt_q <= j2;
      fin_q <= final_pixel_i;
    end
    if (load_job) begin
      cur_q      <= new_job;
      pix_idx_q  <= '0;
      slot_idx_q <= '0;
      first_q    <= 1'b1;
    end else if (rd_en) begin
      pix_idx_q <= pix_idx_q + CntW'(1);
      if (item_done) begin
        item_k_q   <= {1'b0, slot_idx_q} + 3'd1;
        slot_idx_q <= '0;
      end else begin
        slot_idx_q <= slot_idx_q + SlotW'(1);
      end
    end else if (push_raw) begin
      first_q <= 1'b0;
    end
    rd_slot_q <= slot_idx_q;
    if (rd_vld_q) begin
      asm_q[rd_slot_q] <= rdata_q;
    end
  end

  always_comb begin
    for (int i = 0; i < PixelsPerResult; i++) begin
      merged[i] = (rd_vld_q && rd_slot_q == SlotW'(i)) ? rdata_q : asm_q[i];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_run || push_raw) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_run) begin
      hp_q <= 1'b1;
      hb_q <= cur_q.cnt + RunHeaderBias;
      pc_q <= 3'd1;
      pe_q <= 1'b1;
      ie_q <= fin_q && !nxt_vld_q;
      for (int i = 0; i < PixelsPerResult; i++) begin
        slot_q[i] <= (i == 0) ? cur_q.val : '0;
      end
    end else if (push_raw) begin
      hp_q <= first_q;
      hb_q <= first_q ? cur_q.cnt - CntW'(1) : '0;
      pc_q <= item_k_q;
      pe_q <= last_pkt;
      ie_q <= last_pkt && fin_q && !nxt_vld_q;
      for (int i = 0; i < PixelsPerResult; i++) begin
        slot_q[i] <= (3'(i) < item_k_q) ? merged[i] : '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign header_present_o = hp_q;
  assign header_byte_o    = hb_q;
  assign pixel_count_o    = pc_q;
  assign pixel_slot0_o    = slot_q[0];
  assign pixel_slot1_o    = slot_q[1];
  assign pixel_slot2_o    = slot_q[2];
  assign pixel_slot3_o    = slot_q[3];
  assign packet_end_o     = pe_q;
  assign image_end_o      = ie_q;

  a_chunk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_RAW || mode_q == M_RUN) |-> (len_q >= CntW'(2) && !len_q[CntW-1]))
    else $error("chunk length out of range");

  a_final_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && final_pixel_i) |=> (mode_q == M_EMPTY && !in_ready_o))
    else $error("final pixel left chunk state behind");

  a_run_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_present_o && header_byte_o[7]) |->
      (pixel_count_o == 3'd1 && packet_end_o))
    else $error("run packet item malformed");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_count_o != 3'd0 && pixel_count_o <= 3'(PixelsPerResult)))
    else $error("item pixel count out of range");

  a_no_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(push_raw || push_run || rd_en))
    else $error("sequencer active while idle");

endmodule
